// ===== hdl/nbms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Package for the nine-bit multidrop slave: field types, action codes and
// the input word and result word structures. Depends on nothing.
package nbms_pkg;

  localparam logic [6:0] DEVICE_ID_RESET = 7'd10;

  typedef logic [8:0] bus_word_t;
  typedef logic [7:0] byte_t;
  typedef logic [6:0] dev_id_t;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DISCARD = 3'd1,
    ACT_BEGIN   = 3'd2,
    ACT_STORE   = 3'd3,
    ACT_COMMIT  = 3'd4,
    ACT_REJECT  = 3'd5
  } action_t;

  typedef enum logic [0:0] {
    CMD_WORD = 1'b0,
    CMD_SLOT = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_DEVICE_ID    = 1'b0,
    CFG_WAIT_FOR_ACK = 1'b1
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_LISTEN  = 5'b00001,
    ST_POLL    = 5'b00010,
    ST_RECEIVE = 5'b00100,
    ST_SEND    = 5'b01000,
    ST_WAITACK = 5'b10000
  } state_t;

  typedef struct packed {
    cmd_t      cmd;
    bus_word_t rx_word;
    logic      framing_error;
    logic      rx_room;
    byte_t     tx_pending;
    byte_t     tx_data;
  } item_t;

  typedef struct packed {
    action_t action;
    byte_t   rx_byte;
    logic    rx_text;
    logic    rx_bcast;
    logic    tx_start;
    byte_t   tx_count;
    logic    tx_valid;
    byte_t   tx_byte;
    logic    tx_release;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/nbms_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel interfaces of the nine-bit multidrop slave: input words, result
// words and configuration writes. Depends on nbms_pkg.
interface nbms_in_if;
  logic                 valid;
  logic                 ready;
  nbms_pkg::cmd_t       cmd;
  nbms_pkg::bus_word_t  rx_word;
  logic                 framing_error;
  logic                 rx_room;
  nbms_pkg::byte_t      tx_pending;
  nbms_pkg::byte_t      tx_data;
  modport source (output valid, cmd, rx_word, framing_error, rx_room, tx_pending, tx_data,
                  input ready);
  modport sink (input valid, cmd, rx_word, framing_error, rx_room, tx_pending, tx_data,
                output ready);
endinterface

interface nbms_out_if;
  logic                 valid;
  logic                 ready;
  nbms_pkg::action_t    action;
  nbms_pkg::byte_t      rx_byte;
  logic                 rx_text;
  logic                 rx_bcast;
  logic                 tx_start;
  nbms_pkg::byte_t      tx_count;
  logic                 tx_valid;
  nbms_pkg::byte_t      tx_byte;
  logic                 tx_release;
  modport source (output valid, action, rx_byte, rx_text, rx_bcast, tx_start,
                  tx_count, tx_valid, tx_byte, tx_release, input ready);
  modport sink (input valid, action, rx_byte, rx_text, rx_bcast, tx_start,
                tx_count, tx_valid, tx_byte, tx_release, output ready);
endinterface

interface nbms_cfg_if;
  logic                   valid;
  logic                   ready;
  nbms_pkg::cfg_index_t   index;
  nbms_pkg::dev_id_t      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/nbms_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Protocol engine of the nine-bit multidrop slave: frame state and the
// one-word step that yields a result word. Depends on nbms_pkg.
module nbms_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire nbms_pkg::item_t   item,
  input  wire nbms_pkg::dev_id_t device_id,
  input  wire logic              wait_for_ack,
  output nbms_pkg::result_t      res
);
  import nbms_pkg::*;

  state_t     state_r, state_nxt, eff_state;
  byte_t      sum_r, sum_nxt;
  logic [6:0] count_r, count_nxt, count_inc;
  logic [5:0] len_r, len_nxt;
  logic       bcast_r, bcast_nxt;
  logic       text_r, text_nxt;
  byte_t      remain_r, remain_nxt, remain_dec;
  bus_word_t  w;

  assign w          = item.rx_word;
  assign count_inc  = count_r + 7'd1;
  assign remain_dec = remain_r - 8'd1;

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    count_nxt  = count_r;
    len_nxt    = len_r;
    bcast_nxt  = bcast_r;
    text_nxt   = text_r;
    remain_nxt = remain_r;
    res        = '0;
    eff_state  = w[8] ? ST_LISTEN : state_r;
    if (item.cmd == CMD_SLOT) begin
      if (state_r == ST_SEND) begin
        res.tx_valid = 1'b1;
        res.tx_byte  = item.tx_data;
        remain_nxt   = remain_dec;
        if (remain_dec == 8'd0) begin
          if (wait_for_ack) begin
            state_nxt = ST_WAITACK;
          end else begin
            res.tx_release = 1'b1;
            state_nxt      = ST_LISTEN;
          end
        end
      end
    end else if (item.framing_error) begin
      state_nxt  = ST_LISTEN;
      res.action = ACT_DISCARD;
    end else begin
      case (eff_state)
        ST_POLL: begin
          state_nxt = ST_LISTEN;
          if (w == {2'b01, device_id}) begin
            res.tx_start = 1'b1;
            if (item.tx_pending == 8'd0) begin
              res.tx_count = 8'd1;
              res.tx_valid = 1'b1;
            end else begin
              res.tx_count = item.tx_pending;
              remain_nxt   = item.tx_pending;
              state_nxt    = ST_SEND;
            end
          end
        end
        ST_RECEIVE: begin
          sum_nxt   = sum_r + w[7:0];
          count_nxt = count_inc;
          if (count_inc == 7'd2) begin
            len_nxt  = w[5:0];
            text_nxt = w[7];
          end else if (count_inc == {1'b0, len_r} + 7'd3) begin
            state_nxt = ST_LISTEN;
            if (sum_nxt == 8'd0) begin
              res.action   = ACT_COMMIT;
              res.rx_text  = text_r;
              res.rx_bcast = bcast_r;
              res.tx_byte  = 8'd0;
            end else begin
              res.action  = ACT_REJECT;
              res.tx_byte = 8'd1;
            end
            if (!bcast_r) begin
              res.tx_start = 1'b1;
              res.tx_count = 8'd1;
              res.tx_valid = 1'b1;
            end else begin
              res.tx_byte = 8'd0;
            end
          end else begin
            res.action  = ACT_STORE;
            res.rx_byte = w[7:0];
          end
        end
        ST_SEND: begin
          state_nxt = ST_LISTEN;
        end
        ST_WAITACK: begin
          res.tx_release = (w == 9'd0);
          state_nxt      = ST_LISTEN;
        end
        default: begin
          state_nxt = ST_LISTEN;
          if (w == {2'b10, device_id} || w == 9'h100) begin
            if (item.rx_room) begin
              state_nxt  = ST_RECEIVE;
              count_nxt  = 7'd1;
              sum_nxt    = w[7:0];
              bcast_nxt  = (w == 9'h100);
              res.action = ACT_BEGIN;
            end
          end else if (w == {2'b11, device_id}) begin
            state_nxt = ST_POLL;
          end else begin
            res.action = ACT_DISCARD;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LISTEN;
      sum_r    <= '0;
      count_r  <= '0;
      len_r    <= '0;
      bcast_r  <= 1'b0;
      text_r   <= 1'b0;
      remain_r <= '0;
    end else if (en) begin
      state_r  <= state_nxt;
      sum_r    <= sum_nxt;
      count_r  <= count_nxt;
      len_r    <= len_nxt;
      bcast_r  <= bcast_nxt;
      text_r   <= text_nxt;
      remain_r <= remain_nxt;
    end
  end

  a_store_stays: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.action == ACT_STORE |=> state_r == ST_RECEIVE)
    else $error("store byte left the receive state");
  a_bcast_silent: assert property (@(posedge clk) disable iff (!rst_n)
    res.action == ACT_COMMIT && res.rx_bcast |-> !res.tx_valid)
    else $error("broadcast frame was answered");
  a_begin_counts: assert property (@(posedge clk) disable iff (!rst_n)
    en && res.action == ACT_BEGIN |=> count_r == 7'd1)
    else $error("frame start did not reset the word count");
  a_slot_only_send: assert property (@(posedge clk) disable iff (!rst_n)
    item.cmd == CMD_SLOT && state_r != ST_SEND |-> res == '0)
    else $error("transmit slot acted outside sending");

endmodule
`default_nettype wire

// ===== hdl/nine_bit_multidrop_slave_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Nine-bit multidrop bus slave, top level.
// Channels: in_bus takes one word per event, either a received bus word or a
// free transmit slot, with the receiver flags and the transmit buffer status.
// out_bus returns exactly one result word for every input word, in order,
// telling the host what to do with the receive buffer and the bus driver.
// cfg_bus writes the device address (index 0) and the wait-for-ack flag
// (index 1); it is always ready. The user must write it only while the block
// is idle; the block does not enforce this. A word accepted from in_bus sits
// in the input register, passes the protocol engine and its result word is
// captured in the result register. Throughput is one word per cycle while
// out_bus is ready; the engine state update is a single compare-and-add step
// between the registers. After reset the slave listens with address 10,
// wait-for-ack off, and both pipeline registers empty. When the receiver
// stalls, the result register holds its word, the input register keeps one
// more, and in_bus.ready drops until out_bus.ready returns.
// Depends on nbms_pkg, nbms_if and nbms_engine.
module nine_bit_multidrop_slave_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  nbms_in_if.sink    in_bus,
  nbms_out_if.source out_bus,
  nbms_cfg_if.sink   cfg_bus
);
  import nbms_pkg::*;

  logic    in_vld_r;
  item_t   in_item_r;
  logic    out_vld_r;
  result_t out_res_r;
  result_t eng_res;
  dev_id_t device_id_r;
  logic    wait_for_ack_r;
  logic    advance;
  item_t   in_item;

  assign advance       = in_vld_r && (!out_vld_r || out_bus.ready);
  assign in_bus.ready  = !in_vld_r || advance;
  assign cfg_bus.ready = 1'b1;

  assign in_item.cmd           = in_bus.cmd;
  assign in_item.rx_word       = in_bus.rx_word;
  assign in_item.framing_error = in_bus.framing_error;
  assign in_item.rx_room       = in_bus.rx_room;
  assign in_item.tx_pending    = in_bus.tx_pending;
  assign in_item.tx_data       = in_bus.tx_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r    <= DEVICE_ID_RESET;
      wait_for_ack_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        CFG_DEVICE_ID:    device_id_r    <= cfg_bus.data;
        CFG_WAIT_FOR_ACK: wait_for_ack_r <= cfg_bus.data[0];
        default:          device_id_r    <= device_id_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_vld_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      in_item_r <= in_item;
    end
  end

  nbms_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (advance),
    .item         (in_item_r),
    .device_id    (device_id_r),
    .wait_for_ack (wait_for_ack_r),
    .res          (eng_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= eng_res;
    end
  end

  assign out_bus.valid      = out_vld_r;
  assign out_bus.action     = out_res_r.action;
  assign out_bus.rx_byte    = out_res_r.rx_byte;
  assign out_bus.rx_text    = out_res_r.rx_text;
  assign out_bus.rx_bcast   = out_res_r.rx_bcast;
  assign out_bus.tx_start   = out_res_r.tx_start;
  assign out_bus.tx_count   = out_res_r.tx_count;
  assign out_bus.tx_valid   = out_res_r.tx_valid;
  assign out_bus.tx_byte    = out_res_r.tx_byte;
  assign out_bus.tx_release = out_res_r.tx_release;

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> in_vld_r && out_vld_r && !out_bus.ready)
    else $error("input stalled without a full pipeline");
  a_start_sends: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.tx_start && out_res_r.action != ACT_NONE |-> out_res_r.tx_valid)
    else $error("frame answer started without a byte");
  a_release_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_res_r.tx_release |-> out_res_r.action == ACT_NONE)
    else $error("release combined with a receive action");
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("processed word produced no result");

endmodule
`default_nettype wire
